// ----- hdl/opc_pkg.sv -----
`default_nettype none

package opc_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W       = 13;
    localparam int COLOR_W     = 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [COL_W-1:0]      t_col_idx;
    typedef logic [COLOR_W-1:0]    t_color;
    typedef logic [8:0]            t_window;
    typedef logic [FIFO_CNT_W-1:0] t_fifo_count;

    localparam t_count CNT_MAX = '1;

    // window bit = column * 3 + row; column 0 is the right side, row 0 the top
    localparam t_window WIN_LEFT   = 9'b111_000_000;
    localparam t_window WIN_RIGHT  = 9'b000_000_111;
    localparam t_window WIN_TOP    = 9'b001_001_001;
    localparam t_window WIN_BOTTOM = 9'b100_100_100;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_INK_COLOR    = 2'd2,
        CFG_PAPER_COLOR  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_window win;
        logic    last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef struct packed {
        t_fifo_count count;
        t_item       head;
    } t_fifo_stat;

endpackage

`default_nettype wire

// ----- hdl/opc_front.sv -----
`default_nettype none

module opc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_pixel_filled,
    input  logic                 i_padding,
    input  opc_pkg::t_count      i_frame_width,
    input  opc_pkg::t_count      i_frame_height,
    input  opc_pkg::t_fifo_count i_fifo_count,
    output opc_pkg::t_push       o_push
);
    import opc_pkg::*;

    logic [1:0] r_line_mem [MAX_WIDTH];

    t_count   r_col, r_row, r_ecol, r_erow;
    t_count   n_col, n_row, n_ecol, n_erow;
    t_window  r_win;

    logic     r_s1_valid;
    logic     r_s1_emit;
    logic     r_s1_last;
    t_window  r_s1_mask;
    t_col_idx r_s1_col;
    logic     r_s1_pix;
    logic     r_s1_fwd;
    logic [1:0] r_s1_fwd_data;
    logic [1:0] r_mem_q;

    t_count   w_eff, h_eff, wm1, hm1;
    logic     accept, pix, emit, ec_end, er_end, last;
    t_window  mask;
    t_col_idx col_idx;
    logic [1:0] rd, wr_data;
    t_window  win_new;
    logic     s1_push;

    always_comb begin
        if (i_frame_width == '0) begin
            w_eff = t_count'(1);
        end else if (i_frame_width > t_count'(MAX_WIDTH)) begin
            w_eff = t_count'(MAX_WIDTH);
        end else begin
            w_eff = i_frame_width;
        end
        if (i_frame_height == '0) begin
            h_eff = t_count'(1);
        end else if (i_frame_height > t_count'(MAX_HEIGHT)) begin
            h_eff = t_count'(MAX_HEIGHT);
        end else begin
            h_eff = i_frame_height;
        end
    end

    assign wm1     = w_eff - t_count'(1);
    assign hm1     = h_eff - t_count'(1);
    assign s1_push = r_s1_valid && r_s1_emit;
    assign o_stall = (i_fifo_count + t_fifo_count'(s1_push)) >= t_fifo_count'(FIFO_DEPTH);
    assign accept  = i_valid && !o_stall;
    assign pix     = i_pixel_filled && !i_padding;
    assign col_idx = r_col[COL_W-1:0];

    // the result for the centre pixel trails the input by one row plus one pixel
    assign emit   = (r_row >= t_count'(2)) || (r_row == t_count'(1) && r_col != '0);
    assign ec_end = r_ecol >= wm1;
    assign er_end = r_erow >= hm1;
    assign last   = ec_end && er_end;

    always_comb begin
        mask = '1;
        if (r_ecol == '0) begin
            mask = mask & ~WIN_LEFT;
        end
        if (ec_end) begin
            mask = mask & ~WIN_RIGHT;
        end
        if (r_erow == '0) begin
            mask = mask & ~WIN_TOP;
        end
        if (er_end) begin
            mask = mask & ~WIN_BOTTOM;
        end
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ecol = r_ecol;
        n_erow = r_erow;
        if (accept) begin
            if (r_col >= wm1) begin
                n_col = '0;
                if (r_row != CNT_MAX) begin
                    n_row = r_row + t_count'(1);
                end
            end else begin
                n_col = r_col + t_count'(1);
            end
            if (emit) begin
                if (last) begin
                    n_col  = '0;
                    n_row  = '0;
                    n_ecol = '0;
                    n_erow = '0;
                end else if (ec_end) begin
                    n_ecol = '0;
                    if (r_erow != CNT_MAX) begin
                        n_erow = r_erow + t_count'(1);
                    end
                end else begin
                    n_ecol = r_ecol + t_count'(1);
                end
            end
        end
    end

    // second stage: line data arrives, window shifts, line buffer is written back
    assign rd      = r_s1_fwd ? r_s1_fwd_data : r_mem_q;
    assign wr_data = {r_s1_pix, rd[1]};
    assign win_new = {r_win[5:0], r_s1_pix, rd[1], rd[0]};

    assign o_push.valid     = s1_push;
    assign o_push.item.win  = win_new & r_s1_mask;
    assign o_push.item.last = r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_ecol     <= '0;
            r_erow     <= '0;
            r_win      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_ecol     <= n_ecol;
            r_erow     <= n_erow;
            r_s1_valid <= accept;
            if (r_s1_valid) begin
                r_win <= (r_s1_emit && r_s1_last) ? '0 : win_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit     <= emit;
            r_s1_last     <= last;
            r_s1_mask     <= mask;
            r_s1_col      <= col_idx;
            r_s1_pix      <= pix;
            // same column as the write in flight: take the data being written
            r_s1_fwd      <= r_s1_valid && (r_s1_col == col_idx);
            r_s1_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= wr_data;
        end
        if (accept) begin
            r_mem_q <= r_line_mem[col_idx];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/opc_fifo.sv -----
`default_nettype none

module opc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  opc_pkg::t_push      i_push,
    input  logic                i_pop,
    output opc_pkg::t_fifo_stat o_stat
);
    import opc_pkg::*;

    t_item r_data [FIFO_DEPTH];

    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    t_fifo_count           r_count;

    assign o_stat.count = r_count;
    assign o_stat.head  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + t_fifo_count'(i_push.valid) - t_fifo_count'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/opc_back.sv -----
`default_nettype none

module opc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  opc_pkg::t_fifo_stat i_fifo,
    output logic                o_pop,
    input  opc_pkg::t_color     i_ink_color,
    input  opc_pkg::t_color     i_paper_color,
    output logic                o_valid,
    input  logic                i_stall,
    output opc_pkg::t_color     o_color_index,
    output logic                o_is_outline,
    output logic                o_last_of_frame
);
    import opc_pkg::*;

    function automatic logic classify(input t_window win);
        logic       n, s, w, e, nw, ne, sw, se, a, b, res;
        logic [2:0] sides;
        n  = win[3];
        s  = win[5];
        w  = win[7];
        e  = win[1];
        nw = win[6];
        ne = win[0];
        sw = win[8];
        se = win[2];
        sides = 3'(n) + 3'(s) + 3'(w) + 3'(e);
        if (n) begin
            a = nw;
            b = ne;
        end else if (s) begin
            a = sw;
            b = se;
        end else if (w) begin
            a = nw;
            b = sw;
        end else begin
            a = ne;
            b = se;
        end
        if (!win[4] || sides == 3'd0 || sides == 3'd4) begin
            res = 1'b0;
        end else if (sides == 3'd1) begin
            res = (a == b);
        end else begin
            res = (nw || ne || sw || se) || (w && e) || (n && s);
        end
        return res;
    endfunction

    logic r_valid;
    logic outline;

    assign o_pop   = (i_fifo.count != '0) && (!r_valid || !i_stall);
    assign outline = classify(i_fifo.head.win);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_color_index   <= outline ? i_ink_color : i_paper_color;
            o_is_outline    <= outline;
            o_last_of_frame <= i_fifo.head.last;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/outline_pixel_classifier.sv -----
// the result for a pixel is formed from the item that completes its 3x3 window,
//   which is one row plus one pixel after the pixel itself
// throughput: one item per cycle unless stalled, limited by the single line buffer read/write port
// reset: synchronous, active low; counters, window, queue and configuration return
//   to their defaults, the line buffer is not cleared and needs no clearing pass
`default_nettype none

module outline_pixel_classifier (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_pixel_filled,
    input  logic                i_padding,
    output logic                o_valid,
    input  logic                i_stall,
    output opc_pkg::t_color     o_color_index,
    output logic                o_is_outline,
    output logic                o_last_of_frame,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  opc_pkg::t_cfg_index i_cfg_index,
    input  opc_pkg::t_count     i_cfg_data
);
    import opc_pkg::*;

    t_count     r_frame_width, r_frame_height;
    t_color     r_ink_color, r_paper_color;
    t_push      push;
    t_fifo_stat fifo_stat;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= t_count'(640);
            r_frame_height <= t_count'(480);
            r_ink_color    <= t_color'(0);
            r_paper_color  <= t_color'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_INK_COLOR:    r_ink_color    <= i_cfg_data[COLOR_W-1:0];
                CFG_PAPER_COLOR:  r_paper_color  <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    opc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_filled (i_pixel_filled),
        .i_padding      (i_padding),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_fifo_count   (fifo_stat.count),
        .o_push         (push)
    );

    opc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (fifo_stat)
    );

    opc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fifo          (fifo_stat),
        .o_pop           (pop),
        .i_ink_color     (r_ink_color),
        .i_paper_color   (r_paper_color),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_color_index   (o_color_index),
        .o_is_outline    (o_is_outline),
        .o_last_of_frame (o_last_of_frame)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> (fifo_stat.count != t_fifo_count'(FIFO_DEPTH)))
        else $error("transaction pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (fifo_stat.count != '0))
        else $error("transaction popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.count <= t_fifo_count'(FIFO_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- bench/outline_pixel_classifier_checker.sv -----
module outline_pixel_classifier_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pix_valid,
    input  logic                i_pix_stall,
    input  logic                i_pix_filled,
    input  logic                i_pix_padding,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  opc_pkg::t_color     i_res_color,
    input  logic                i_res_outline,
    input  logic                i_res_last,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  opc_pkg::t_cfg_index i_cfg_index,
    input  opc_pkg::t_count     i_cfg_data,
    output int                  o_mismatches,
    output int                  o_pending,
    output int                  o_frames_done
);

    import opc_pkg::*;

    typedef struct packed {
        t_color color;
        logic   outline;
        logic   last;
    } t_pixel_verdict;

    t_pixel_verdict pending_verdicts[$];

    logic        line_above [MAX_WIDTH];
    logic        line_centre [MAX_WIDTH];
    t_window     window;
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;

    t_count      width_reg;
    t_count      height_reg;
    t_color      ink_reg;
    t_color      paper_reg;

    int          mismatch_total;
    int          frame_total;

    function automatic int unsigned clamp_span(t_count value, int unsigned cap);
        if (value == 0) begin
            return 1;
        end
        if (value > cap) begin
            return cap;
        end
        return value;
    endfunction

    // window bit = column * 3 + row, column 0 on the right, row 0 on top
    function automatic logic is_edge_pixel(t_window win);
        logic n, s, w, e, nw, ne, sw, se;
        logic a, b;
        int   sides;
        n  = win[3];
        s  = win[5];
        w  = win[7];
        e  = win[1];
        nw = win[6];
        ne = win[0];
        sw = win[8];
        se = win[2];
        sides = int'(n) + int'(s) + int'(w) + int'(e);
        if (!win[4] || sides == 0 || sides == 4) begin
            return 1'b0;
        end
        if (sides == 1) begin
            if (n) begin
                a = nw;
                b = ne;
            end else if (s) begin
                a = sw;
                b = se;
            end else if (w) begin
                a = nw;
                b = sw;
            end else begin
                a = ne;
                b = se;
            end
            return a == b;
        end
        if (!(nw | ne | sw | se) && !((w && e) || (n && s))) begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic classify_pixel(input logic filled, input logic pad);
        int unsigned    span_w;
        int unsigned    span_h;
        logic           pix;
        logic           top;
        logic           mid;
        logic           emit;
        t_window        masked;
        t_pixel_verdict verdict;
        span_w = clamp_span(width_reg, MAX_WIDTH);
        span_h = clamp_span(height_reg, MAX_HEIGHT);
        pix = pad ? 1'b0 : filled;
        top = 1'b0;
        mid = 1'b0;
        if (in_col < MAX_WIDTH) begin
            top = line_above[in_col];
            mid = line_centre[in_col];
            line_above[in_col] = mid;
            line_centre[in_col] = pix;
        end
        window = {window[5:0], pix, mid, top};

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col >= span_w - 1) begin
            in_col = 0;
            if (in_row < CNT_MAX) begin
                in_row++;
            end
        end else begin
            in_col++;
        end
        if (!emit) begin
            return;
        end

        // neighbours outside the frame count as unfilled
        masked = window;
        if (out_col == 0) begin
            masked &= ~WIN_LEFT;
        end
        if (out_col >= span_w - 1) begin
            masked &= ~WIN_RIGHT;
        end
        if (out_row == 0) begin
            masked &= ~WIN_TOP;
        end
        if (out_row >= span_h - 1) begin
            masked &= ~WIN_BOTTOM;
        end
        verdict.outline = is_edge_pixel(masked);
        verdict.color = verdict.outline ? ink_reg : paper_reg;
        verdict.last = (out_row >= span_h - 1) && (out_col >= span_w - 1);
        pending_verdicts.insert(pending_verdicts.size(), verdict);

        if (verdict.last) begin
            window = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else if (out_col >= span_w - 1) begin
            out_col = 0;
            if (out_row < CNT_MAX) begin
                out_row++;
            end
        end else begin
            out_col++;
        end
    endtask

    task automatic report_result(input string what, input t_pixel_verdict want,
                                 input t_pixel_verdict got);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $display("%s: expected color %0d outline %0b last %0b, got color %0d outline %0b last %0b",
                     what, want.color, want.outline, want.last,
                     got.color, got.outline, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_verdict want;
        t_pixel_verdict got;
        if (!i_rst_n) begin
            pending_verdicts.delete();
            line_above = '{default: 1'b0};
            line_centre = '{default: 1'b0};
            window = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            width_reg = 640;
            height_reg = 480;
            ink_reg = 0;
            paper_reg = 1;
            mismatch_total = 0;
            frame_total = 0;
        end else begin
            // a result always belongs to an earlier transaction, so check it first
            if (i_res_valid && !i_res_stall) begin
                got.color = i_res_color;
                got.outline = i_res_outline;
                got.last = i_res_last;
                if (got.last === 1'b1) begin
                    frame_total++;
                end
                if (pending_verdicts.size() == 0) begin
                    report_result("result with nothing pending", '0, got);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (want.color !== got.color || want.outline !== got.outline
                            || want.last !== got.last) begin
                        report_result("result mismatch", want, got);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  width_reg = i_cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_data;
                    CFG_INK_COLOR:    ink_reg = i_cfg_data[COLOR_W-1:0];
                    CFG_PAPER_COLOR:  paper_reg = i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && !i_pix_stall) begin
                classify_pixel(i_pix_filled, i_pix_padding);
            end
        end
        o_mismatches = mismatch_total;
        o_pending = pending_verdicts.size();
        o_frames_done = frame_total;
    end

endmodule

// ----- bench/outline_pixel_classifier_tb.sv -----
module outline_pixel_classifier_tb;

    import opc_pkg::*;

    localparam int IDLE_PCT      = 36;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DIRECTED_PIX  = 141;
    localparam int RANDOM_PIX    = 1760;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_pixel_filled = 1'b0;
    logic       i_padding = 1'b0;
    logic       i_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    t_cfg_index i_cfg_index = CFG_FRAME_WIDTH;
    t_count     i_cfg_data = '0;

    logic       o_stall;
    logic       o_valid;
    t_color     o_color_index;
    logic       o_is_outline;
    logic       o_last_of_frame;
    logic       o_cfg_ready;

    int         mismatches;
    int         pending;
    int         frames_done;

    bit         steady = 1'b0;
    int         hold_reqs = 0;
    int         holds_done = 0;
    int         quiet_cycles = 0;
    int         pixels_sent = 0;

    always #4 i_clk = ~i_clk;

    outline_pixel_classifier i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_filled  (i_pixel_filled),
        .i_padding       (i_padding),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_color_index   (o_color_index),
        .o_is_outline    (o_is_outline),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    outline_pixel_classifier_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_valid),
        .i_pix_stall   (o_stall),
        .i_pix_filled  (i_pixel_filled),
        .i_pix_padding (i_padding),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_res_color   (o_color_index),
        .i_res_outline (o_is_outline),
        .i_res_last    (o_last_of_frame),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_frames_done (frames_done)
    );

    // result side: random stalls, or one long hold-off when asked for
    initial begin
        forever begin
            @(negedge i_clk);
            if (holds_done < hold_reqs) begin
                holds_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("outline_pixel_classifier_tb failed");
            $finish;
        end
    end

    function automatic int unsigned frame_span(t_count value, int unsigned cap);
        if (value == 0) begin
            return 1;
        end
        if (value > cap) begin
            return cap;
        end
        return value;
    endfunction

    task automatic send_pixel(input logic filled, input logic pad);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_filled <= filled;
        i_padding <= pad;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_pixels(input int count, input int fill_pct, input int pad_pct);
        repeat (count) begin
            send_pixel($urandom_range(99) < fill_pct, $urandom_range(99) < pad_pct);
        end
    endtask

    // sender pauses until every predicted result is out, then lets the pipe settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_count value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_config(input t_count w, input t_count h, input t_count ink,
                               input t_count paper);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_INK_COLOR, ink);
        write_reg(CFG_PAPER_COLOR, paper);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_frame(input t_count w, input t_count h, input int fill_pct);
        int unsigned span_w;
        int unsigned span_h;
        load_config(w, h, t_count'($urandom_range(8191)), t_count'($urandom_range(8191)));
        span_w = frame_span(w, MAX_WIDTH);
        span_h = frame_span(h, MAX_HEIGHT);
        send_pixels(span_w * span_h, fill_pct, 4);
        // flush items, some of them filled but not marked as padding
        send_pixels(span_w + 1, fill_pct, 75);
    endtask

    // one transaction at a time until the block closes the current frame
    task automatic finish_frame();
        int start;
        start = frames_done;
        while (frames_done == start) begin
            send_pixel(1'($urandom_range(1)), $urandom_range(3) != 0);
            i_valid <= 1'b0;
            @(negedge i_clk);
            while (pending != 0) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [0:11] shape;
        int          frame_no;
        t_count      w;
        t_count      h;
        int          pick;
        int          fill;

        shape = 12'b1110_1111_0111;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 40-wide frame first so every line buffer column in use has been written
        run_frame(40, 2, 50);

        // hand-made 4x3 frame, padding inside it and filled pixels after it
        load_config(4, 3, 0, 255);
        for (int i = 0; i < 12; i++) begin
            send_pixel(shape[i], i == 6);
        end
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b0, 1'b1);
        send_pixel(1'b1, 1'b1);
        send_pixel(1'b0, 1'b0);
        // single pixel frame, colors above 8 bits
        load_config(1, 1, 8191, 0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b0);
        send_pixel(1'b1, 1'b1);

        frame_no = 0;
        while (pixels_sent < DIRECTED_PIX + RANDOM_PIX) begin
            pick = $urandom_range(99);
            w = (pick < 4) ? t_count'(0) :
                (pick < 10) ? t_count'($urandom_range(12, 40)) : t_count'($urandom_range(1, 10));
            h = ($urandom_range(99) < 4) ? t_count'(0) : t_count'($urandom_range(1, 8));
            fill = $urandom_range(10, 90);
            if (frame_no == 12) begin
                steady = 1'b1;
                w = 10;
                h = 8;
            end
            if (frame_no == 25) begin
                hold_reqs++;
                w = 8;
                h = 8;
            end
            if (frame_no != 12 && frame_no != 25 && $urandom_range(9) == 0) begin
                // cut a frame short, resize while it is open, then run it out
                load_config(w, h, t_count'($urandom_range(8191)),
                            t_count'($urandom_range(8191)));
                send_pixels($urandom_range(1, frame_span(w, MAX_WIDTH) * frame_span(h, MAX_HEIGHT)),
                            fill, 4);
                load_config(t_count'($urandom_range(1, 9)), t_count'($urandom_range(1, 6)),
                            t_count'($urandom_range(8191)), t_count'($urandom_range(8191)));
                finish_frame();
            end else begin
                run_frame(w, h, fill);
            end
            steady = 1'b0;
            frame_no++;
        end

        // size values past the legal range on an open frame, then a small one
        load_config(8191, 8191, 8191, 0);
        send_pixels(30, 50, 4);
        load_config(3, 2, t_count'($urandom_range(8191)), t_count'($urandom_range(8191)));
        finish_frame();
        run_frame(3, 2, 80);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("outline_pixel_classifier_tb passed");
        end else begin
            $display("outline_pixel_classifier_tb failed");
        end
        $finish;
    end

endmodule
